@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; users provide clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

@@ rtl/core/pts_pkg.sv @@
// Shared types and constants for the periodic task scheduler.
// Depends on nothing; used by the top level and pts_satadd.
package pts_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_TASK_DONE = 3'd1;
    localparam logic [2:0] CMD_ADD_TASK  = 3'd2;
    localparam logic [2:0] CMD_ADD_MUTEX = 3'd3;
    localparam logic [2:0] CMD_ACQUIRE   = 3'd4;
    localparam logic [2:0] CMD_RELEASE   = 3'd5;
    localparam logic [2:0] CMD_ENABLE    = 3'd6;

    // Slot usage kinds
    localparam logic [1:0] USE_NONE  = 2'd0;
    localparam logic [1:0] USE_TASK  = 2'd1;
    localparam logic [1:0] USE_MUTEX = 2'd2;

    // Configuration register indexes (paddr[2])
    localparam logic REG_SLOTS_IN_USE    = 1'b0;
    localparam logic REG_MUTEXES_ENABLED = 1'b1;

    localparam int PADDR_W  = 3;
    localparam int PERIOD_W = 16;
    localparam int TTR_W    = 32;

    localparam logic [TTR_W-1:0] TTR_MAX = 32'h7fff_ffff;
    localparam logic [TTR_W-1:0] TTR_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [3:0]          slot;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] elapsed;
        logic                enable_flag;
    } item_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] scheduled_task;
        logic       fresh_launch;
        logic       switched;
    } result_t;

endpackage

@@ rtl/core/pts_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/pts_satadd.sv @@
// Shared saturating adder for the countdown values.
// Depends on pts_pkg for widths and saturation bounds.
module pts_satadd (
    input  logic [pts_pkg::TTR_W-1:0] a,
    input  logic [pts_pkg::PERIOD_W:0] b,
    output logic [pts_pkg::TTR_W-1:0] sum
);

    logic [pts_pkg::TTR_W:0] wide;

    // Add with sign extension, clamp on signed overflow
    always_comb
    begin
        wide = {a[pts_pkg::TTR_W-1], a}
             + {{(pts_pkg::TTR_W - pts_pkg::PERIOD_W){b[pts_pkg::PERIOD_W]}}, b};
        if (wide[pts_pkg::TTR_W] != wide[pts_pkg::TTR_W-1])
        begin
            sum = wide[pts_pkg::TTR_W] ? pts_pkg::TTR_MIN : pts_pkg::TTR_MAX;
        end
        else
        begin
            sum = wide[pts_pkg::TTR_W-1:0];
        end
    end

endmodule

@@ rtl/core/periodic_task_scheduler_ceiling.sv @@
// Top level of the priority-ceiling periodic task scheduler.
// Depends on pts_pkg, pts_ram, pts_satadd and assert_macros.svh.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------
//  command  | start / busy                   | item   (pts_pkg::item_t)
//  result   | done, one cycle, no backpress. | result (pts_pkg::result_t)
//  config   | APB psel/penable/pwrite, ready | pwdata / prdata, paddr
//
// A tick walks the slots below lim through one adder, one slot per cycle,
// lim being slots_in_use capped at NUM_SLOTS; after the scan drains, a pick
// state registers the chosen task and strobes the result, and the block is
// busy from the scan through the pick state. Task done goes through its own
// state (countdown read, then write back); other commands answer from idle.
// Reset clears the slot kinds, flags and current task; period, countdown and
// priority memories hold garbage until a task is added. The receiver cannot
// stall: a result is shown for one cycle while the next command may start.
`include "assert_macros.svh"

module periodic_task_scheduler_ceiling #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pts_pkg::item_t               item,
    output logic                         done,
    output pts_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pts_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] MAIN_CODE = CW'(NUM_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration registers
    logic [4:0] slots_in_use_reg;
    logic       mutexes_enabled_reg;

    // Control state
    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        cur_task_reg, cur_task_next;
    logic [1:0]           usage_reg [NUM_SLOTS];
    logic [1:0]           usage_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] enabled_reg, enabled_next;
    logic [NUM_SLOTS-1:0] running_reg, running_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 ex_vld_reg, ex_vld_next;
    logic                 done_reg, done_next;

    // Payload registers
    logic [SW-1:0]                ex_idx_reg, ex_idx_next;
    logic [CW-1:0]                best_reg, best_next;
    logic [CW-1:0]                pick_reg, pick_next;
    logic [pts_pkg::PERIOD_W-1:0] elapsed_reg, elapsed_next;
    pts_pkg::result_t             result_reg, result_next;

    // Memory ports
    logic [SW-1:0]                raddr;
    logic                         ttr_we;
    logic [SW-1:0]                ttr_waddr;
    logic [pts_pkg::TTR_W-1:0]    ttr_wdata;
    logic [pts_pkg::TTR_W-1:0]    ttr_rdata;
    logic                         prio_we;
    logic [SW-1:0]                prio_waddr;
    logic [SW-1:0]                prio_wdata;
    logic [SW-1:0]                prio_rdata;
    logic                         per_we;
    logic [pts_pkg::PERIOD_W-1:0] per_rdata;

    // Shared adder operands
    logic [pts_pkg::PERIOD_W:0]   add_b;
    logic [pts_pkg::TTR_W-1:0]    add_sum;

    // Decoded helpers
    logic [CW-1:0] lim;
    logic          accept;
    logic          cur_is_task;
    logic [SW-1:0] cur_idx;
    logic [SW-1:0] slot_idx;
    logic [SW-1:0] pick_idx;
    logic          slot_in_lim;
    logic          slot_exists;
    logic          ex_active;
    logic          ex_ready;

    assign lim = (int'(slots_in_use_reg) > NUM_SLOTS) ? MAIN_CODE : CW'(slots_in_use_reg);
    assign accept      = start && (state_reg == S_IDLE);
    assign cur_is_task = (cur_task_reg != MAIN_CODE);
    assign cur_idx     = cur_task_reg[SW-1:0];
    assign pick_idx    = pick_reg[SW-1:0];
    assign slot_idx    = SW'(item.slot);
    assign slot_in_lim = int'(item.slot) < int'(lim);
    assign slot_exists = int'(item.slot) < NUM_SLOTS;

    // Read the scan slot while walking, else the current task's slot
    assign raddr = (state_reg == S_SCAN) ? rd_idx_reg[SW-1:0] : cur_idx;

    // Subtract elapsed time while scanning, add the period on task done
    assign add_b = (state_reg == S_SCAN)
                 ? ((pts_pkg::PERIOD_W + 1)'(0) - {1'b0, elapsed_reg})
                 : {1'b0, per_rdata};

    assign ex_active = (usage_reg[ex_idx_reg] == pts_pkg::USE_TASK) && enabled_reg[ex_idx_reg];
    assign ex_ready  = add_sum[pts_pkg::TTR_W-1] || (add_sum == '0);

    pts_satadd u_satadd (
        .a   (ttr_rdata),
        .b   (add_b),
        .sum (add_sum)
    );

    pts_ram #(.WIDTH(pts_pkg::TTR_W), .DEPTH(NUM_SLOTS)) u_ttr_ram (
        .clk   (clk),
        .we    (ttr_we),
        .waddr (ttr_waddr),
        .wdata (ttr_wdata),
        .raddr (raddr),
        .rdata (ttr_rdata)
    );

    pts_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (prio_waddr),
        .wdata (prio_wdata),
        .raddr (raddr),
        .rdata (prio_rdata)
    );

    pts_ram #(.WIDTH(pts_pkg::PERIOD_W), .DEPTH(NUM_SLOTS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (slot_idx),
        .wdata (item.period),
        .raddr (raddr),
        .rdata (per_rdata)
    );

    // Sequencer and command decode
    always_comb
    begin
        state_next    = state_reg;
        cur_task_next = cur_task_reg;
        usage_next    = usage_reg;
        enabled_next  = enabled_reg;
        running_next  = running_reg;
        rd_idx_next   = rd_idx_reg;
        ex_vld_next   = 1'b0;
        ex_idx_next   = ex_idx_reg;
        best_next     = best_reg;
        pick_next     = pick_reg;
        elapsed_next  = elapsed_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ttr_we        = 1'b0;
        ttr_waddr     = cur_idx;
        ttr_wdata     = add_sum;
        prio_we       = 1'b0;
        prio_waddr    = cur_idx;
        prio_wdata    = cur_idx;
        per_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.ok             = 1'b1;
                    result_next.scheduled_task = 5'(cur_task_reg);
                    result_next.fresh_launch   = 1'b0;
                    result_next.switched       = 1'b0;
                    done_next                  = 1'b1;
                    case (item.cmd)
                        pts_pkg::CMD_TICK:
                        begin
                            elapsed_next = item.elapsed;
                            rd_idx_next  = '0;
                            best_next    = lim;
                            pick_next    = MAIN_CODE;
                            done_next    = 1'b0;
                            state_next   = S_SCAN;
                        end
                        pts_pkg::CMD_TASK_DONE:
                        begin
                            if (cur_is_task)
                            begin
                                running_next[cur_idx] = 1'b0;
                                done_next             = 1'b0;
                                state_next            = S_DONE;
                            end
                        end
                        pts_pkg::CMD_ADD_TASK:
                        begin
                            if (slot_in_lim)
                            begin
                                usage_next[slot_idx]   = pts_pkg::USE_TASK;
                                enabled_next[slot_idx] = 1'b1;
                                running_next[slot_idx] = 1'b0;
                                ttr_we                 = 1'b1;
                                ttr_waddr              = slot_idx;
                                ttr_wdata              = pts_pkg::TTR_W'(item.period);
                                per_we                 = 1'b1;
                                prio_we                = 1'b1;
                                prio_waddr             = slot_idx;
                                prio_wdata             = slot_idx;
                            end
                            else
                            begin
                                result_next.ok = 1'b0;
                            end
                        end
                        pts_pkg::CMD_ADD_MUTEX:
                        begin
                            if (slot_in_lim)
                            begin
                                usage_next[slot_idx] = pts_pkg::USE_MUTEX;
                            end
                            else
                            begin
                                result_next.ok = 1'b0;
                            end
                        end
                        pts_pkg::CMD_ACQUIRE:
                        begin
                            if (cur_is_task && mutexes_enabled_reg && slot_exists
                                && (usage_reg[slot_idx] == pts_pkg::USE_MUTEX))
                            begin
                                prio_we    = 1'b1;
                                prio_wdata = slot_idx;
                            end
                        end
                        pts_pkg::CMD_RELEASE:
                        begin
                            prio_we = cur_is_task;
                        end
                        pts_pkg::CMD_ENABLE:
                        begin
                            if (slot_in_lim && (usage_reg[slot_idx] == pts_pkg::USE_TASK))
                            begin
                                enabled_next[slot_idx] = item.enable_flag;
                            end
                        end
                        default:
                        begin
                            result_next.ok = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read, or drain and move on
                if (rd_idx_reg < lim)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    ex_vld_next = 1'b1;
                    ex_idx_next = rd_idx_reg[SW-1:0];
                end
                else if (!ex_vld_reg)
                begin
                    state_next = S_PICK;
                end
                // Age the returning slot and track the best ready one
                if (ex_vld_reg && ex_active)
                begin
                    ttr_we    = 1'b1;
                    ttr_waddr = ex_idx_reg;
                    if (ex_ready && (CW'(prio_rdata) < best_reg))
                    begin
                        best_next = CW'(prio_rdata);
                        pick_next = CW'(ex_idx_reg);
                    end
                end
            end

            S_PICK:
            begin
                result_next.ok             = 1'b1;
                result_next.scheduled_task = 5'(pick_reg);
                result_next.fresh_launch   = 1'b0;
                result_next.switched       = (pick_reg != cur_task_reg);
                if (pick_reg != MAIN_CODE)
                begin
                    result_next.fresh_launch = !running_reg[pick_idx];
                    running_next[pick_idx]   = 1'b1;
                end
                cur_task_next = pick_reg;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            S_DONE:
            begin
                // Countdown and period of the current slot are valid now
                ttr_we     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_task_reg <= MAIN_CODE;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                usage_reg[i] <= pts_pkg::USE_NONE;
            end
            enabled_reg  <= '0;
            running_reg  <= '0;
            rd_idx_reg   <= '0;
            ex_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_task_reg <= cur_task_next;
            usage_reg    <= usage_next;
            enabled_reg  <= enabled_next;
            running_reg  <= running_next;
            rd_idx_reg   <= rd_idx_next;
            ex_vld_reg   <= ex_vld_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ex_idx_reg  <= ex_idx_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        elapsed_reg <= elapsed_next;
        result_reg  <= result_next;
    end

    // Configuration write on the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg    <= 5'd16;
            mutexes_enabled_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                pts_pkg::REG_SLOTS_IN_USE: slots_in_use_reg    <= pwdata[4:0];
                default:                   mutexes_enabled_reg <= pwdata[0];
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        case (paddr[2])
            pts_pkg::REG_MUTEXES_ENABLED: prdata = {31'b0, mutexes_enabled_reg};
            default:                      prdata = {27'b0, slots_in_use_reg};
        endcase
    end

    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_HOLDS(a_done_only_idle, done_reg |-> (state_reg == S_IDLE), "result strobe outside idle")
    `ASSERT_HOLDS(a_quick_cmd_one_cycle, (accept && (item.cmd != pts_pkg::CMD_TICK) && (item.cmd != pts_pkg::CMD_TASK_DONE)) |=> done_reg, "single-cycle command lost its result")
    `ASSERT_HOLDS(a_scan_in_range, (state_reg == S_SCAN) |-> (rd_idx_reg <= lim), "scan index ran past slot limit")
    `ASSERT_HOLDS(a_pick_valid, (state_reg == S_PICK) |-> ((pick_reg == MAIN_CODE) || (pick_reg < lim)), "picked slot outside slot limit")
    `ASSERT_NEVER(a_fresh_main, done_reg && result_reg.fresh_launch && (cur_task_reg == MAIN_CODE), "main loop flagged as fresh launch")

endmodule
